// ===== design/midpoint_ellipse_rasterizer_defines.svh =====
// Assertion helpers for the rasterizer RTL.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define MER_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// Next-cycle implication, checked only while out of reset.
`define MER_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rasterizer check failed");

`endif

// ===== design/mer_pkg.sv =====
`default_nettype none

package mer_pkg;

  localparam int unsigned MER_RADIUS_BITS = 11;
  localparam int unsigned MER_COORD_BITS  = 12;

  // Request opcodes.
  localparam logic OPC_START = 1'b0;
  localparam logic OPC_STEP  = 1'b1;

  // Microprogram addresses.
  typedef enum logic [4:0] {
    U_ST0  = 5'd0,  U_ST1  = 5'd1,  U_ST2  = 5'd2,  U_ST3  = 5'd3,
    U_ST4  = 5'd4,  U_ST5  = 5'd5,
    U_SP0  = 5'd6,  U_SP1  = 5'd7,  U_SP2  = 5'd8,
    U_R1A  = 5'd9,  U_R1B  = 5'd10, U_R1C  = 5'd11, U_R1D  = 5'd12,
    U_R1E  = 5'd13, U_R1N0 = 5'd14, U_R1N1 = 5'd15,
    U_R2S0 = 5'd16, U_R2S1 = 5'd17, U_R2S2 = 5'd18, U_R2S3 = 5'd19,
    U_R2S4 = 5'd20, U_R2S5 = 5'd21,
    U_R2A  = 5'd22, U_R2B  = 5'd23, U_R2C  = 5'd24, U_R2D  = 5'd25,
    U_R2E  = 5'd26, U_R2P0 = 5'd27, U_R2P1 = 5'd28,
    U_NOP  = 5'd29
  } upc_e;

  // Multiplier operand sources.
  typedef enum logic [2:0] {
    SRC_X, SRC_Y, SRC_TX, SRC_TY, SRC_RX2, SRC_RY2, SRC_ONE, SRC_P
  } src_e;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_e;
  typedef enum logic [1:0] {SH0, SH2, SH3} sh_e;
  typedef enum logic [1:0] {X_HOLD, X_INC, X_CLR} xop_e;
  typedef enum logic [2:0] {J_NONE, J_ALWAYS, J_R2, J_NLT, J_DNEG, J_DPOS} jmp_e;

  typedef struct packed {
    src_e ma;
    src_e mb;
    acc_e acc;
    sh_e  sh;
    xop_e xop;
    logic y_dec;
    logic wr_rx2;
    logic wr_ry2;
    logic set_r2;
    jmp_e jmp;
    upc_e target;
    logic emit;
    logic emit_zero;
  } ctrl_t;

  // Control store. The multiplier result is registered in the product
  // register, so the accumulate field of a word works on the product that
  // the previous word started.
  function automatic ctrl_t ucode(upc_e a);
    ctrl_t c;
    c = '0;
    unique case (a)
      U_ST0: begin c.ma = SRC_X; c.mb = SRC_X; end
      U_ST1: begin c.ma = SRC_Y; c.mb = SRC_Y; c.wr_rx2 = 1'b1; c.xop = X_CLR; end
      U_ST2: begin c.ma = SRC_RX2; c.mb = SRC_ONE; c.wr_ry2 = 1'b1; end
      U_ST3: begin c.ma = SRC_RY2; c.mb = SRC_ONE; c.acc = ACC_LOAD; c.sh = SH0; end
      U_ST4: begin c.ma = SRC_RX2; c.mb = SRC_Y; c.acc = ACC_ADD; c.sh = SH2; end
      U_ST5: begin c.acc = ACC_SUB; c.sh = SH2; c.emit = 1'b1; end
      U_SP0: begin
        c.ma = SRC_RY2; c.mb = SRC_X; c.jmp = J_R2; c.target = U_R2A;
      end
      U_SP1: begin c.ma = SRC_RX2; c.mb = SRC_Y; end
      U_SP2: begin c.jmp = J_NLT; c.target = U_R2S0; end
      U_R1A: begin c.xop = X_INC; c.jmp = J_DNEG; c.target = U_R1N0; end
      U_R1B: begin c.y_dec = 1'b1; c.ma = SRC_RY2; c.mb = SRC_X; end
      U_R1C: begin c.ma = SRC_RX2; c.mb = SRC_Y; c.acc = ACC_ADD; c.sh = SH3; end
      U_R1D: begin c.ma = SRC_RY2; c.mb = SRC_ONE; c.acc = ACC_SUB; c.sh = SH3; end
      U_R1E: begin c.acc = ACC_ADD; c.sh = SH2; c.emit = 1'b1; end
      U_R1N0: begin c.ma = SRC_RY2; c.mb = SRC_X; end
      U_R1N1: begin
        c.ma = SRC_RY2; c.mb = SRC_ONE; c.acc = ACC_ADD; c.sh = SH3;
        c.jmp = J_ALWAYS; c.target = U_R1E;
      end
      U_R2S0: begin c.ma = SRC_TX; c.mb = SRC_TX; c.set_r2 = 1'b1; end
      U_R2S1: begin c.ma = SRC_RY2; c.mb = SRC_P; end
      U_R2S2: begin c.ma = SRC_TY; c.mb = SRC_TY; c.acc = ACC_LOAD; c.sh = SH0; end
      U_R2S3: begin c.ma = SRC_RX2; c.mb = SRC_P; end
      U_R2S4: begin c.ma = SRC_RX2; c.mb = SRC_RY2; c.acc = ACC_ADD; c.sh = SH2; end
      U_R2S5: begin c.acc = ACC_SUB; c.sh = SH2; end
      U_R2A: begin c.y_dec = 1'b1; c.jmp = J_DPOS; c.target = U_R2P0; end
      U_R2B: begin c.xop = X_INC; c.ma = SRC_RX2; c.mb = SRC_Y; end
      U_R2C: begin c.ma = SRC_RY2; c.mb = SRC_X; c.acc = ACC_SUB; c.sh = SH3; end
      U_R2D: begin c.ma = SRC_RX2; c.mb = SRC_ONE; c.acc = ACC_ADD; c.sh = SH3; end
      U_R2E: begin c.acc = ACC_ADD; c.sh = SH2; c.emit = 1'b1; end
      U_R2P0: begin c.ma = SRC_RX2; c.mb = SRC_Y; end
      U_R2P1: begin
        c.ma = SRC_RX2; c.mb = SRC_ONE; c.acc = ACC_SUB; c.sh = SH3;
        c.jmp = J_ALWAYS; c.target = U_R2E;
      end
      U_NOP: begin c.emit = 1'b1; c.emit_zero = 1'b1; end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/midpoint_ellipse_rasterizer.sv =====
// One request at a time: a start runs the setup program, a step runs the
// region-1 or region-2 iteration (the step that enters region 2 also runs
// the region-2 setup), and a step while idle gives a registered empty result.
// The next request is taken the cycle after the emit; one product per step.
// Reset (async, active low) clears the sequencer, the busy and region flags
// and the output valid; the block is idle and ready right after reset.
`default_nettype none
`include "midpoint_ellipse_rasterizer_defines.svh"

module midpoint_ellipse_rasterizer
  import mer_pkg::*;
#(
  parameter int unsigned RADIUS_BITS = MER_RADIUS_BITS,
  parameter int unsigned COORD_BITS  = MER_COORD_BITS
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           op_i,
  input  wire        [COORD_BITS-1:0]   center_x_i,
  input  wire        [COORD_BITS-1:0]   center_y_i,
  input  wire        [RADIUS_BITS-1:0]  radius_x_i,
  input  wire        [RADIUS_BITS-1:0]  radius_y_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [COORD_BITS+1:0]  px_right_o,
  output logic signed [COORD_BITS+1:0]  px_left_o,
  output logic signed [COORD_BITS+1:0]  py_top_o,
  output logic signed [COORD_BITS+1:0]  py_bottom_o,
  output logic       [RADIUS_BITS-1:0]  offset_x_o,
  output logic       [RADIUS_BITS-1:0]  offset_y_o,
  output logic                          points_valid_o,
  output logic                          last_set_o
);

  // Multiplier operand width covers (2x+1)^2 and the squared radii.
  localparam int unsigned MW  = 2 * RADIUS_BITS + 2;
  localparam int unsigned PW  = 2 * MW;
  // The decision variable holds four times the real midpoint decision, so
  // the 0.25 and 0.5 terms of the textbook form become whole numbers.
  localparam int unsigned DEC = 3 * RADIUS_BITS + 7;
  localparam int unsigned OUT = COORD_BITS + 2;
  localparam int unsigned SW  =
      ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  // Sequencer state.
  logic  run_q, run_d;
  upc_e  upc_q, upc_d;
  ctrl_t cw;
  logic  adv;
  logic  in_acc;
  logic  take;
  upc_e  entry;

  // Datapath registers.
  logic [RADIUS_BITS-1:0]   x_q, x_d;
  logic [RADIUS_BITS-1:0]   y_q, y_d;
  logic [DEC-1:0]           d_q, d_d;
  logic [DEC-1:0]           p_q, p2_q;
  logic [2*RADIUS_BITS-1:0] rx2_q, ry2_q;
  logic [COORD_BITS-1:0]    cx_q, cy_q;
  logic                     r2_q;
  logic                     busy_q;
  logic                     out_valid_q;

  logic [MW-1:0]  opa, opb;
  logic [PW-1:0]  prod;
  logic [DEC-1:0] pshift;
  logic           lt;
  logic [SW-1:0]  cx_ext, cy_ext, x_ext, y_ext;
  logic [SW-1:0]  sum_xr, sum_xl, sum_yt, sum_yb;

  // The control word comes straight from the ROM at the current address.
  assign cw = ucode(upc_q);

  // A request is taken only while the sequencer sits idle. The output
  // register decouples the two sides, so a new request may enter while an
  // earlier result is still waiting to be taken.
  assign in_ready_o = !run_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // A step advances unless it wants to emit while the output is still full.
  assign adv = run_q && !(cw.emit && out_valid_q && !out_ready_i);

  // Region test: ry2*x < rx2*y, both products exact in DEC bits.
  assign lt = p2_q < p_q;

  // Start requests run the setup program, steps on a live ellipse run the
  // iteration program, and a step with nothing in progress gives an empty
  // result.
  always_comb begin
    priority if (op_i == OPC_START) begin
      entry = U_ST0;
    end else if (busy_q) begin
      entry = U_SP0;
    end else begin
      entry = U_NOP;
    end
  end

  // Next address: conditional jump or fall through.
  always_comb begin
    unique case (cw.jmp)
      J_NONE:   take = 1'b0;
      J_ALWAYS: take = 1'b1;
      J_R2:     take = r2_q;
      J_NLT:    take = !lt;
      J_DNEG:   take = d_q[DEC-1];
      J_DPOS:   take = !d_q[DEC-1] && (d_q != '0);
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    run_d = run_q;
    upc_d = upc_q;
    if (!run_q) begin
      if (in_valid_i) begin
        run_d = 1'b1;
        upc_d = entry;
      end
    end else if (adv) begin
      upc_d = take ? cw.target : upc_e'(upc_q + 5'd1);
      if (cw.emit) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      upc_q <= U_ST0;
    end else begin
      run_q <= run_d;
      upc_q <= upc_d;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cw.ma)
      SRC_X:   opa = {{(MW-RADIUS_BITS){1'b0}}, x_q};
      SRC_Y:   opa = {{(MW-RADIUS_BITS){1'b0}}, y_q};
      SRC_TX:  opa = {{(MW-RADIUS_BITS-1){1'b0}}, x_q, 1'b1};
      SRC_TY:  opa = {{(MW-RADIUS_BITS){1'b0}}, y_q - 1'b1};
      SRC_RX2: opa = {{(MW-2*RADIUS_BITS){1'b0}}, rx2_q};
      SRC_RY2: opa = {{(MW-2*RADIUS_BITS){1'b0}}, ry2_q};
      SRC_ONE: opa = {{(MW-1){1'b0}}, 1'b1};
      SRC_P:   opa = p_q[MW-1:0];
      default: opa = '0;
    endcase
  end

  always_comb begin
    unique case (cw.mb)
      SRC_X:   opb = {{(MW-RADIUS_BITS){1'b0}}, x_q};
      SRC_Y:   opb = {{(MW-RADIUS_BITS){1'b0}}, y_q};
      SRC_TX:  opb = {{(MW-RADIUS_BITS-1){1'b0}}, x_q, 1'b1};
      SRC_TY:  opb = {{(MW-RADIUS_BITS){1'b0}}, y_q - 1'b1};
      SRC_RX2: opb = {{(MW-2*RADIUS_BITS){1'b0}}, rx2_q};
      SRC_RY2: opb = {{(MW-2*RADIUS_BITS){1'b0}}, ry2_q};
      SRC_ONE: opb = {{(MW-1){1'b0}}, 1'b1};
      SRC_P:   opb = p_q[MW-1:0];
      default: opb = '0;
    endcase
  end

  assign prod = opa * opb;

  // Scaled product for the accumulator: times 1, 4 or 8.
  always_comb begin
    unique case (cw.sh)
      SH0:     pshift = p_q;
      SH2:     pshift = {p_q[DEC-3:0], 2'b00};
      SH3:     pshift = {p_q[DEC-4:0], 3'b000};
      default: pshift = p_q;
    endcase
  end

  // Decision accumulator; all arithmetic wraps in DEC bits.
  always_comb begin
    unique case (cw.acc)
      ACC_HOLD: d_d = d_q;
      ACC_LOAD: d_d = pshift;
      ACC_ADD:  d_d = d_q + pshift;
      ACC_SUB:  d_d = d_q - pshift;
      default:  d_d = d_q;
    endcase
  end

  always_comb begin
    unique case (cw.xop)
      X_HOLD:  x_d = x_q;
      X_INC:   x_d = x_q + 1'b1;
      X_CLR:   x_d = '0;
      default: x_d = x_q;
    endcase
    y_d = cw.y_dec ? (y_q - 1'b1) : y_q;
  end

  // Datapath. A start request parks the radii in the offset registers; the
  // setup program squares them and then clears x.
  always_ff @(posedge clk_i) begin
    if (in_acc && (op_i == OPC_START)) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      x_q  <= radius_x_i;
      y_q  <= radius_y_i;
    end else if (adv) begin
      x_q  <= x_d;
      y_q  <= y_d;
      d_q  <= d_d;
      p_q  <= prod[DEC-1:0];
      p2_q <= p_q;
      if (cw.wr_rx2) begin
        rx2_q <= p_q[2*RADIUS_BITS-1:0];
      end
      if (cw.wr_ry2) begin
        ry2_q <= p_q[2*RADIUS_BITS-1:0];
      end
    end
  end

  // Region and busy flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q   <= 1'b0;
      busy_q <= 1'b0;
    end else if (in_acc && (op_i == OPC_START)) begin
      r2_q <= 1'b0;
    end else if (adv) begin
      if (cw.set_r2) begin
        r2_q <= 1'b1;
      end
      if (cw.emit && !cw.emit_zero) begin
        busy_q <= (y_q != '0);
      end
    end
  end

  // Quadrant coordinates, wrapped to the output width.
  assign cx_ext = {{(SW-COORD_BITS){1'b0}}, cx_q};
  assign cy_ext = {{(SW-COORD_BITS){1'b0}}, cy_q};
  assign x_ext  = {{(SW-RADIUS_BITS){1'b0}}, x_q};
  assign y_ext  = {{(SW-RADIUS_BITS){1'b0}}, y_q};
  assign sum_xr = cx_ext + x_ext;
  assign sum_xl = cx_ext - x_ext;
  assign sum_yt = cy_ext + y_ext;
  assign sum_yb = cy_ext - y_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && cw.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cw.emit) begin
      if (cw.emit_zero) begin
        px_right_o     <= '0;
        px_left_o      <= '0;
        py_top_o       <= '0;
        py_bottom_o    <= '0;
        offset_x_o     <= '0;
        offset_y_o     <= '0;
        points_valid_o <= 1'b0;
        last_set_o     <= 1'b0;
      end else begin
        px_right_o     <= $signed(sum_xr[OUT-1:0]);
        px_left_o      <= $signed(sum_xl[OUT-1:0]);
        py_top_o       <= $signed(sum_yt[OUT-1:0]);
        py_bottom_o    <= $signed(sum_yb[OUT-1:0]);
        offset_x_o     <= x_q;
        offset_y_o     <= y_q;
        points_valid_o <= 1'b1;
        last_set_o     <= (y_q == '0);
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // A taken request always lands on one of the three program entries.
  `MER_ASSERT_NXT(a_entry, clk_i, rst_ni, in_valid_i && in_ready_o,
    run_q && (upc_q == U_ST0 || upc_q == U_SP0 || upc_q == U_NOP))
  // An emit blocked by a full output holds the sequencer in place.
  `MER_ASSERT_NXT(a_emit_hold, clk_i, rst_ni,
    run_q && cw.emit && out_valid_o && !out_ready_i,
    run_q && $stable(upc_q) && out_valid_o)
  // Region two is entered only by its setup program.
  `MER_ASSERT_IMP(a_r2_entry, clk_i, rst_ni, $rose(r2_q), $past(upc_q) == U_R2S0)
  // Emitting the set at y = 0 ends the ellipse and flags the result.
  `MER_ASSERT_NXT(a_last_set, clk_i, rst_ni,
    adv && cw.emit && !cw.emit_zero && (y_q == '0),
    !busy_q && out_valid_o && last_set_o)
  // An empty result carries zero offsets.
  `MER_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, out_valid_o && !points_valid_o,
    (offset_x_o == '0) && (offset_y_o == '0) && !last_set_o)

endmodule

`default_nettype wire
